// ===== rtl/pplc_pkg.sv =====
// ----------------------------------------------------------------------------
// pplc_pkg : shared types and constants of the PID position loop
// Widths, fixed-point constants, controller commands and state encoding.
// ----------------------------------------------------------------------------
package pplc_pkg;

  // fixed-point formats
  localparam int FRAC_BITS = 16;   // fraction bits of angles and integral
  localparam int STEP_FRAC = 16;   // fraction bits of step_time

  // field and register widths
  localparam int CNT_W     = 32;
  localparam int ANG_W     = 32;
  localparam int GAIN_W    = 16;
  localparam int PER_W     = 16;
  localparam int MAX_W     = 16;
  localparam int DPC_W     = 24;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  // shared multiplier
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 26;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int SPLIT   = 25;     // low part width of a split wide operand

  // internal value widths
  localparam int INT_W  = 49;      // integral, saturated to +/- 2^47
  localparam int DIFF_W = ANG_W + 1;
  localparam int DER_W  = 50;      // error difference times inverse_step
  localparam int ACC_W  = 67;      // full gain * wide value product
  localparam int CMD_W  = 53;      // sum of the three floored terms

  localparam logic signed [INT_W-1:0] INT_HI = INT_W'(48'h8000_0000_0000);
  localparam logic signed [INT_W-1:0] INT_LO = -INT_HI;
  localparam logic signed [ANG_W-1:0] ANG_MAX = {1'b0, {(ANG_W-1){1'b1}}};
  localparam logic signed [ANG_W-1:0] ANG_MIN = {1'b1, {(ANG_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP, REG_KI, REG_KD, REG_STEP, REG_INV, REG_MAX, REG_DPC
  } cfg_reg_t;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_ANG, MUL_INC, MUL_DER, MUL_KP,
    MUL_KILO, MUL_KIHI, MUL_KDLO, MUL_KDHI
  } mul_op_t;

  typedef enum logic [3:0] {
    POST_NONE, POST_ERR, POST_DIFF, POST_INTG, POST_DERV,
    POST_TKP, POST_LO, POST_HI, POST_LO_TERM, POST_TERM
  } post_op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ANGLE, ST_ERROR, ST_INC, ST_DERIV, ST_KP, ST_KI_LO,
    ST_KI_HI, ST_KD_LO, ST_KD_HI, ST_KD_ADD, ST_KD_TERM, ST_FINISH
  } state_t;

  typedef struct packed {
    mul_op_t  mul;     // operands for the shared multiplier this cycle
    post_op_t post;    // what to do with the registered product
    logic     load;    // capture an input item
    logic     finish;  // saturate, commit state, write the result register
  } ctrl_cmd_t;

endpackage

// ===== rtl/pplc_mul.sv =====
// ----------------------------------------------------------------------------
// pplc_mul : shared signed multiplier
// One signed 33 x 26 product per cycle while en is high, registered.
// ----------------------------------------------------------------------------
module pplc_mul
  import pplc_pkg::*;
(
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end

endmodule

// ===== rtl/pplc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pplc_ctrl : sequencer of the PID position loop
// Steps each item through the multiply schedule and owns the handshakes.
// ----------------------------------------------------------------------------
module pplc_ctrl
  import pplc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output ctrl_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (in_valid) state_next = ST_ANGLE;
      ST_ANGLE:   state_next = ST_ERROR;
      ST_ERROR:   state_next = ST_INC;
      ST_INC:     state_next = ST_DERIV;
      ST_DERIV:   state_next = ST_KP;
      ST_KP:      state_next = ST_KI_LO;
      ST_KI_LO:   state_next = ST_KI_HI;
      ST_KI_HI:   state_next = ST_KD_LO;
      ST_KD_LO:   state_next = ST_KD_HI;
      ST_KD_HI:   state_next = ST_KD_ADD;
      ST_KD_ADD:  state_next = ST_KD_TERM;
      ST_KD_TERM: state_next = ST_FINISH;
      ST_FINISH:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.mul    = MUL_NONE;
    cmd.post   = POST_NONE;
    cmd.load   = 1'b0;
    cmd.finish = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_ANGLE:   cmd.mul = MUL_ANG;
      ST_ERROR:   cmd.post = POST_ERR;
      ST_INC: begin
        cmd.mul  = MUL_INC;
        cmd.post = POST_DIFF;
      end
      ST_DERIV: begin
        cmd.mul  = MUL_DER;
        cmd.post = POST_INTG;
      end
      ST_KP: begin
        cmd.mul  = MUL_KP;
        cmd.post = POST_DERV;
      end
      ST_KI_LO: begin
        cmd.mul  = MUL_KILO;
        cmd.post = POST_TKP;
      end
      ST_KI_HI: begin
        cmd.mul  = MUL_KIHI;
        cmd.post = POST_LO;
      end
      ST_KD_LO: begin
        cmd.mul  = MUL_KDLO;
        cmd.post = POST_HI;
      end
      ST_KD_HI: begin
        cmd.mul  = MUL_KDHI;
        cmd.post = POST_LO_TERM;
      end
      ST_KD_ADD:  cmd.post = POST_HI;
      ST_KD_TERM: cmd.post = POST_TERM;
      ST_FINISH:  cmd.finish = !out_valid || out_ready;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // result slot: fill on finish, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_start_with_angle : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (cmd.mul == MUL_ANG))
    else $error("accepted item did not start with the angle product");

  a_finish_slot_free : assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result written over an untaken result");

  a_valid_from_finish : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_FINISH))
    else $error("result raised outside the finish step");

endmodule

// ===== rtl/pplc_dp.sv =====
// ----------------------------------------------------------------------------
// pplc_dp : datapath of the PID position loop
// Config registers, loop state, shared multiplier and the term accumulator.
// ----------------------------------------------------------------------------
module pplc_dp
  import pplc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_cmd_t            cmd,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [CNT_W-1:0]     position_count,
  input  logic [ANG_W-1:0]     target_angle,
  output logic                 reverse,
  output logic [MAX_W-1:0]     duty,
  output logic                 clamped
);

  // configuration
  logic signed [GAIN_W-1:0] kp, ki, kd;
  logic [PER_W-1:0]         step_time, inverse_step;
  logic [MAX_W-1:0]         cmd_limit;
  logic [DPC_W-1:0]         degrees_per_count;

  // loop state
  logic signed [INT_W-1:0]  error_integral;
  logic signed [ANG_W-1:0]  last_error;

  // per-item working registers
  logic signed [CNT_W-1:0]  count;
  logic signed [ANG_W-1:0]  target;
  logic signed [ANG_W-1:0]  error;
  logic signed [DIFF_W-1:0] diff;
  logic signed [INT_W-1:0]  new_int;
  logic signed [DER_W-1:0]  deriv;
  logic signed [ACC_W-1:0]  acc;
  logic signed [CMD_W-1:0]  command;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] p;
  logic signed [ACC_W-1:0]   p_ext;

  logic signed [MUL_P_W:0]   err_sum;
  logic signed [INT_W+1:0]   int_sum;
  logic signed [CMD_W-1:0]   max_pos, max_neg, sat;
  logic                      over, under, clamp_now;
  logic [CMD_W-1:0]          mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp                <= '0;
      ki                <= '0;
      kd                <= '0;
      step_time         <= PER_W'(655);
      inverse_step      <= PER_W'(100);
      cmd_limit         <= MAX_W'(1000);
      degrees_per_count <= DPC_W'(23593);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_KP:   kp                <= cfg_data[GAIN_W-1:0];
        REG_KI:   ki                <= cfg_data[GAIN_W-1:0];
        REG_KD:   kd                <= cfg_data[GAIN_W-1:0];
        REG_STEP: step_time         <= cfg_data[PER_W-1:0];
        REG_INV:  inverse_step      <= cfg_data[PER_W-1:0];
        REG_MAX:  cmd_limit         <= cfg_data[MAX_W-1:0];
        REG_DPC:  degrees_per_count <= cfg_data[DPC_W-1:0];
        default:  kp                <= kp;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul)
      MUL_ANG: begin
        mul_a = MUL_A_W'(count);
        mul_b = {{(MUL_B_W-DPC_W){1'b0}}, degrees_per_count};
      end
      MUL_INC: begin
        mul_a = MUL_A_W'(error);
        mul_b = {{(MUL_B_W-PER_W){1'b0}}, step_time};
      end
      MUL_DER: begin
        mul_a = diff;
        mul_b = {{(MUL_B_W-PER_W){1'b0}}, inverse_step};
      end
      MUL_KP: begin
        mul_a = MUL_A_W'(error);
        mul_b = MUL_B_W'(kp);
      end
      MUL_KILO: begin
        mul_a = MUL_A_W'(ki);
        mul_b = {{(MUL_B_W-SPLIT){1'b0}}, new_int[SPLIT-1:0]};
      end
      MUL_KIHI: begin
        mul_a = MUL_A_W'(ki);
        mul_b = MUL_B_W'($signed(new_int[INT_W-1:SPLIT]));
      end
      MUL_KDLO: begin
        mul_a = MUL_A_W'(kd);
        mul_b = {{(MUL_B_W-SPLIT){1'b0}}, deriv[SPLIT-1:0]};
      end
      MUL_KDHI: begin
        mul_a = MUL_A_W'(kd);
        mul_b = MUL_B_W'($signed(deriv[DER_W-1:SPLIT]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pplc_mul u_mul (
    .clk (clk),
    .en  (cmd.mul != MUL_NONE),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  assign p_ext   = ACC_W'(p);
  assign err_sum = (MUL_P_W+1)'(target) - (MUL_P_W+1)'(p);
  assign int_sum = (INT_W+2)'(error_integral) + (INT_W+2)'(p >>> STEP_FRAC);

  // saturation of the command
  assign max_pos   = CMD_W'($signed({1'b0, cmd_limit}));
  assign max_neg   = -max_pos;
  assign over      = command > max_pos;
  assign under     = command < max_neg;
  assign sat       = over ? max_pos : (under ? max_neg : command);
  assign clamp_now = (over || under) && ((error > 0) == (command > 0));
  assign mag       = sat[CMD_W-1] ? CMD_W'(-sat) : CMD_W'(sat);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      count  <= position_count;
      target <= target_angle;
    end
    case (cmd.post)
      POST_ERR: begin
        if (err_sum > (MUL_P_W+1)'(ANG_MAX)) begin
          error <= ANG_MAX;
        end else if (err_sum < (MUL_P_W+1)'(ANG_MIN)) begin
          error <= ANG_MIN;
        end else begin
          error <= err_sum[ANG_W-1:0];
        end
      end
      POST_DIFF: diff <= DIFF_W'(error) - DIFF_W'(last_error);
      POST_INTG: begin
        if (int_sum > (INT_W+2)'(INT_HI)) begin
          new_int <= INT_HI;
        end else if (int_sum < (INT_W+2)'(INT_LO)) begin
          new_int <= INT_LO;
        end else begin
          new_int <= int_sum[INT_W-1:0];
        end
      end
      POST_DERV: deriv   <= p[DER_W-1:0];
      POST_TKP:  command <= CMD_W'(p >>> FRAC_BITS);
      POST_LO:   acc     <= p_ext;
      POST_HI:   acc     <= acc + (p_ext <<< SPLIT);
      POST_LO_TERM: begin
        command <= command + CMD_W'(acc >>> FRAC_BITS);
        acc     <= p_ext;
      end
      POST_TERM: command <= command + CMD_W'(acc >>> FRAC_BITS);
      default:   acc     <= acc;
    endcase
  end

  // loop state: hold the integral while clamped
  always_ff @(posedge clk) begin
    if (rst) begin
      error_integral <= '0;
      last_error     <= '0;
    end else if (cmd.finish) begin
      if (!clamp_now) begin
        error_integral <= new_int;
      end
      last_error <= error;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      reverse <= sat[CMD_W-1];
      duty    <= mag[MAX_W-1:0];
      clamped <= clamp_now;
    end
  end

  a_clamp_at_limit : assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (!clamped || duty == cmd_limit))
    else $error("clamped result below the saturation limit");

  a_duty_within_limit : assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (duty <= cmd_limit))
    else $error("duty above the saturation limit");

  a_integral_held : assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && clamp_now) |=> (error_integral == $past(error_integral)))
    else $error("integral moved on a clamped item");

endmodule

// ===== rtl/pid_position_loop_clamp.sv =====
// ----------------------------------------------------------------------------
// pid_position_loop_clamp : PID position loop with clamping anti-windup
// Scales an encoder count to degrees, forms P, I and D terms in fixed point,
// saturates the sum and gives direction, duty and a clamp flag per item.
// ----------------------------------------------------------------------------
// Schedule: each item walks the twelve-step schedule of the single shared
//   33 x 26 multiplier, and a new item is taken only once the last one has
//   finished; a new item is taken while the last result still waits, but
//   finishing stalls until the result slot is free.
// Reset (rst, synchronous): clear the integral and last error, restore the
//   register defaults and empty the result slot.
// ----------------------------------------------------------------------------
module pid_position_loop_clamp
  import pplc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // slave side: [31:0] position_count, [63:32] target_angle
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [63:0]          s_axis_tdata,
  // master side: [0] reverse, [16:1] duty, [17] clamped, [23:18] zero
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [23:0]          m_axis_tdata,
  // configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  ctrl_cmd_t        cmd;
  logic             reverse;
  logic [MAX_W-1:0] duty;
  logic             clamped;

  // sequencer: walks each item through the multiply schedule
  pplc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  // datapath: registers, loop state, shared multiplier, result register
  pplc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .position_count (s_axis_tdata[CNT_W-1:0]),
    .target_angle   (s_axis_tdata[CNT_W+ANG_W-1:CNT_W]),
    .reverse        (reverse),
    .duty           (duty),
    .clamped        (clamped)
  );

  // pack the result, low field first, padded to whole bytes
  assign m_axis_tdata = {6'b0, clamped, duty, reverse};

endmodule

// ===== tb/pid_position_loop_clamp_tb.sv =====
// ----------------------------------------------------------------------------
// pid_position_loop_clamp_tb : self-checking bench for the PID position loop
// Feeds encoder samples through the slave stream and predicts every drive
// result (direction, duty, clamp flag) from a cycle-free fixed-point model of
// the loop. Gains and scales are changed between phases while the loop is
// idle; sender gaps and receiver stalls vary per phase, one phase holds the
// output off long enough to back the loop up, and a short run of one-sided
// error winds the integral up before a full-range swing of the error.
// ----------------------------------------------------------------------------
module pid_position_loop_clamp_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pplc_pkg::*;

  localparam int unsigned QUIET_LIMIT     = 5000;   // cycles with no handshake and no register write
  localparam int unsigned HOLD_LEN        = 400;    // long output hold-off
  localparam int unsigned RAND_PHASES     = 8;
  localparam int unsigned ITEMS_PER_PHASE = 222;
  localparam int unsigned PRESSURE_PHASE  = 4;
  localparam int unsigned WINDUP_ITEMS    = 24;     // short one-sided run
  localparam int unsigned TAIL_CYCLES     = 40;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7; // no register lives here
  localparam longint INTEG_CEIL = 64'sh8000_0000_0000;

  // one drive result, as carried on m_axis_tdata
  typedef struct {
    logic             reverse;
    logic [MAX_W-1:0] duty;
    logic             clamped;
  } drive_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [63:0]          s_axis_tdata = '0;  // [31:0] position_count, [63:32] target_angle
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [23:0]          m_axis_tdata;       // [0] reverse, [16:1] duty, [17] clamped
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  pid_position_loop_clamp dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // mirror of the loop's registers, at their reset values
  logic signed [GAIN_W-1:0] gain_p = '0;
  logic signed [GAIN_W-1:0] gain_i = '0;
  logic signed [GAIN_W-1:0] gain_d = '0;
  logic [PER_W-1:0]         step_q16 = 16'd655;
  logic [PER_W-1:0]         rate_hz = 16'd100;
  logic [MAX_W-1:0]         duty_limit = 16'd1000;
  logic [DPC_W-1:0]         deg_per_count = 24'd23593;

  // mirror of the loop's state
  longint                   integ_acc = 0;
  logic signed [ANG_W-1:0]  prev_err = '0;

  logic [63:0]  sample_queue[$];
  drive_t       expected_drive[$];
  int unsigned  samples_queued = 0;
  int unsigned  samples_taken = 0;
  int unsigned  mismatches = 0;
  int unsigned  quiet_cycles = 0;
  bit           item_taken = 1'b0;
  int unsigned  send_idle_pct = 0;
  int unsigned  stall_pct = 0;
  bit           pressure_on = 1'b0;
  int unsigned  hold_left = HOLD_LEN;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic longint clamp_wide(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Work out the drive result of one sample and advance the mirrored state.
  // All products fit in 64 bits: the widest, kd times the scaled error step,
  // stays just under 2^63.
  function automatic drive_t predict_drive(input logic [63:0] word);
    longint angle, err, inc, integ_next, rate_term, cmd, lim, sat, mag;
    drive_t res;
    angle      = longint'($signed(word[31:0])) * longint'(deg_per_count);
    err        = clamp_wide(longint'($signed(word[63:32])) - angle,
                            longint'(ANG_MIN), longint'(ANG_MAX));
    inc        = (err * longint'(step_q16)) >>> STEP_FRAC;
    integ_next = clamp_wide(integ_acc + inc, -INTEG_CEIL, INTEG_CEIL);
    rate_term  = (err - longint'(prev_err)) * longint'(rate_hz);
    cmd        = ((longint'(gain_p) * err) >>> FRAC_BITS)
               + ((longint'(gain_i) * integ_next) >>> FRAC_BITS)
               + ((longint'(gain_d) * rate_term) >>> FRAC_BITS);
    lim        = longint'(duty_limit);
    sat        = clamp_wide(cmd, -lim, lim);
    // zero error counts as "not positive", so it pairs with a non-positive command
    res.clamped = (sat != cmd) && ((err > 0) == (cmd > 0));
    if (!res.clamped) integ_acc = integ_next;
    prev_err    = err[ANG_W-1:0];
    res.reverse = (sat < 0);
    mag         = (sat < 0) ? -sat : sat;
    res.duty    = mag[MAX_W-1:0];
    return res;
  endfunction

  function automatic logic [GAIN_W-1:0] random_gain();
    // half of the gains stay modest so that not every command saturates
    if ($urandom_range(1, 0) != 0) return GAIN_W'($urandom());
    return GAIN_W'($urandom_range(4000, 0) - 2000);
  endfunction

  // Mostly samples that track the target closely, so the loop works in its
  // linear range; the rest are random targets and wholly random words.
  function automatic logic [63:0] random_sample();
    logic signed [31:0] count, target;
    longint             aim;
    int unsigned        pick;
    pick  = $urandom_range(99, 0);
    count = $signed($urandom()) >>> $urandom_range(31, 0);
    if (pick < 65) begin
      aim    = longint'(count) * longint'(deg_per_count)
             + (longint'($signed($urandom())) >>> $urandom_range(31, 6));
      aim    = clamp_wide(aim, longint'(ANG_MIN), longint'(ANG_MAX));
      target = aim[31:0];
    end else if (pick < 85) begin
      target = $urandom();
    end else begin
      count  = $urandom();
      target = $urandom();
    end
    return {target, count};
  endfunction

  task automatic queue_sample(input logic [63:0] word);
    sample_queue.push_back(word);
    samples_queued++;
  endtask

  // Hold until every queued sample has been taken and every result has come.
  task automatic wait_drained();
    while (samples_taken != samples_queued || expected_drive.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
  endtask

  task automatic close_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
                               input logic [GAIN_W-1:0] d, input logic [PER_W-1:0] step,
                               input logic [PER_W-1:0] rate, input logic [MAX_W-1:0] lim,
                               input logic [DPC_W-1:0] dpc);
    write_reg(REG_KP, CFG_W'(p));
    write_reg(REG_KI, CFG_W'(i));
    write_reg(REG_KD, CFG_W'(d));
    write_reg(REG_STEP, CFG_W'(step));
    write_reg(REG_INV, CFG_W'(rate));
    write_reg(REG_MAX, CFG_W'(lim));
    write_reg(REG_DPC, CFG_W'(dpc));
    close_writes();
  endtask

  // Sender: offer the next pending sample, or idle at random; hold an item
  // that has not yet been taken.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || item_taken) begin
      if (sample_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        s_axis_tdata  <= sample_queue.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random, except in the pressure phase, where it first
  // holds off for a long stretch so that the loop backs up to its input.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (pressure_on && hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  // Monitor: mirror register writes, predict on each taken sample, check each
  // result against the oldest prediction, and watch for a stuck run.
  always @(posedge clk) begin : monitor
    drive_t want;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KP:   gain_p = cfg_data[GAIN_W-1:0];
          REG_KI:   gain_i = cfg_data[GAIN_W-1:0];
          REG_KD:   gain_d = cfg_data[GAIN_W-1:0];
          REG_STEP: step_q16 = cfg_data[PER_W-1:0];
          REG_INV:  rate_hz = cfg_data[PER_W-1:0];
          REG_MAX:  duty_limit = cfg_data[MAX_W-1:0];
          REG_DPC:  deg_per_count = cfg_data[DPC_W-1:0];
          default:  ;  // writes to a spare index leave every register alone
        endcase
      end
      item_taken = s_axis_tvalid && s_axis_tready;
      if (item_taken) begin
        expected_drive.push_back(predict_drive(s_axis_tdata));
        samples_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_drive.size() == 0) begin
          $error("result with no prediction waiting: tdata %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_drive.pop_front();
          if (m_axis_tdata[0] !== want.reverse) begin
            $error("reverse: expected %0d, actual %0d", want.reverse, m_axis_tdata[0]);
            mismatches++;
          end
          if (m_axis_tdata[16:1] !== want.duty) begin
            $error("duty: expected %0d, actual %0d", want.duty, m_axis_tdata[16:1]);
            mismatches++;
          end
          if (m_axis_tdata[17] !== want.clamped) begin
            $error("clamped: expected %0d, actual %0d", want.clamped, m_axis_tdata[17]);
            mismatches++;
          end
        end
      end
      if (item_taken || (m_axis_tvalid && m_axis_tready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  initial begin : sequencer
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // reset values: gains are zero, so only the state update is exercised
    queue_sample({32'sd0, 32'sd0});
    queue_sample({ANG_MIN, ANG_MAX});
    wait_drained();

    // directed setting; a write to the spare index must change nothing
    apply_setting(16'sd2000, 16'sd100, 16'sd50, 16'd655, 16'd100, 16'd1000, 24'd23593);
    write_reg(REG_SPARE, 24'hA5_A5A5);
    close_writes();
    queue_sample({32'sd0, 32'sd0});
    queue_sample({32'sd0, 32'sd1});
    queue_sample({32'sd0, -32'sd1});
    queue_sample({ANG_MAX, 32'sd0});
    queue_sample({ANG_MIN, 32'sd0});
    queue_sample({32'sd0, ANG_MAX});          // scaled angle far above range
    queue_sample({32'sd0, ANG_MIN});          // scaled angle far below range
    queue_sample({ANG_MIN, ANG_MIN});
    queue_sample({ANG_MAX, ANG_MAX});
    queue_sample({32'sd2359305, 32'sd100});   // five units off the target
    wait_drained();

    // zero limit: any nonzero command gives zero duty; zero error with a
    // saturated command, once positive (not clamped), once negative (clamped)
    write_reg(REG_MAX, 24'd0);
    write_reg(REG_KD, CFG_W'(16'sh8000));
    close_writes();
    queue_sample({32'sh0001_0000, 32'sd0});
    queue_sample({32'sd0, 32'sd0});
    queue_sample({-32'sh0001_0000, 32'sd0});
    queue_sample({32'sd0, 32'sd0});
    wait_drained();

    // zero period and zero rate freeze the integral and drop the derivative term
    write_reg(REG_STEP, 24'd0);
    write_reg(REG_INV, 24'd0);
    write_reg(REG_MAX, 24'hFFFF);
    close_writes();
    queue_sample({32'sd0, 32'sd5});
    queue_sample({32'sd7777, -32'sd5});

    // random phases, each with its own setting and idling pattern
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0:       apply_setting(16'sd800, 16'sd40, 16'sd200, 16'd655, 16'd100, 16'd1000,
                               24'd23593);
        1:       apply_setting(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               24'hFF_FFFF);
        2:       apply_setting(16'sh8000, 16'sh8000, 16'sh8000, 16'd1, 16'd1, 16'd0, 24'd1);
        default: apply_setting(random_gain(), random_gain(), random_gain(),
                               16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)),
                               16'($urandom_range(65535, 0)),
                               24'($urandom_range(24'hFF_FFFF, 1)));
      endcase
      case (ph % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 54; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 54; end
        default: begin send_idle_pct = 31; stall_pct = 31; end
      endcase
      pressure_on = (ph == PRESSURE_PHASE);
      repeat (ITEMS_PER_PHASE) queue_sample(random_sample());
    end
    wait_drained();
    pressure_on   = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;

    // Windup: with ki negative the command opposes a positive error, so it
    // never clamps and the integral climbs at full rate.
    apply_setting(16'sd0, -16'sd1, 16'sd0, 16'hFFFF, 16'd100, 16'hFFFF, 24'd23593);
    repeat (WINDUP_ITEMS) queue_sample({ANG_MAX, 32'sd0});
    wait_drained();

    // Swing the error between its extremes with a small derivative gain: a
    // most-negative error against the wound-up integral clamps and leaves the
    // integral alone, and each swing drives the derivative term at full range.
    write_reg(REG_KD, 24'd1);
    write_reg(REG_INV, 24'd32768);
    close_writes();
    repeat (3) begin
      queue_sample({ANG_MIN, 32'sd0});
      queue_sample({ANG_MAX, 32'sd0});
    end
    wait_drained();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_drive.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
